// File: sv/list_scheduling_makespan_core_assert.svh
// Assertion macros shared by the list scheduling makespan core.
`ifndef LIST_SCHEDULING_MAKESPAN_CORE_ASSERT_SVH
`define LIST_SCHEDULING_MAKESPAN_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high.
`define LSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define LSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LSM_ASSERT(label, clk, rst, prop, msg)
`define LSM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: sv/lsm_pkg.sv
// Types, constants and helper functions for the list scheduling makespan core.
package lsm_pkg;

   // Default number of stage cells in the ring.
   localparam int LSM_MAX_STAGES = 16;

   // Field widths.
   localparam int FINISH_W = 32;
   localparam int DUR_W = 16;
   localparam int CSR_W = 5;

   // Reset value of the stage count register.
   localparam logic [CSR_W-1:0] STAGE_COUNT_RESET = 5'd1;

   // Controls shared by every cell of the ring.
   typedef struct packed {
      logic                shift;
      logic                clear;
      logic [FINISH_W-1:0] wdata;
   } lsm_cell_ctrl_type;

   // Finish time plus a duration, saturating at the top of the range.
   function automatic logic [FINISH_W-1:0] sat_add(input logic [FINISH_W-1:0] base,
                                                   input logic [DUR_W-1:0] dur);
      logic [FINISH_W:0] wide;
      wide = {1'b0, base} + {{(FINISH_W+1-DUR_W){1'b0}}, dur};
      sat_add = wide[FINISH_W] ? {FINISH_W{1'b1}} : wide[FINISH_W-1:0];
   endfunction

endpackage

// File: sv/list_scheduling_makespan_core.sv
// The ring of stage cells rotates once per request past a single min/max comparator;
// then the update state writes the chosen stage. A new request is taken only in idle
// or as the update of the previous request completes.
// Reset is synchronous and active high: all finish times clear, stage count returns to 1.
// A full result register holds its makespan until taken and stalls only the final update.
module list_scheduling_makespan_core
   import lsm_pkg::*;
#(
   parameter int MAX_STAGES = LSM_MAX_STAGES
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [DUR_W-1:0]    req_duration,
   input  logic                req_last_job,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FINISH_W-1:0] rsp_makespan
);

`include "list_scheduling_makespan_core_assert.svh"

   localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int CNT_W = $clog2(MAX_STAGES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_STAGES - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic [FINISH_W-1:0] min_ff, min_in;
   logic [FINISH_W-1:0] max_ff, max_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic                last_ff, last_in;
   logic [CSR_W-1:0]    stage_count_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FINISH_W-1:0] rsp_makespan_ff, rsp_makespan_in;

   logic [CNT_W-1:0]    stages_used;
   logic                req_accept;
   logic                upd_done;
   logic                rsp_free;
   logic [FINISH_W-1:0] sum_sat;
   logic [FINISH_W-1:0] head;
   lsm_cell_ctrl_type   cell_ctrl;
   logic [FINISH_W-1:0] finish [MAX_STAGES];
   logic [MAX_STAGES-1:0] cell_load;
   logic [MAX_STAGES-1:0] cell_busy;

   // Stage count register; write only while idle (the block itself does not enforce this).
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= STAGE_COUNT_RESET;
      end else if (csr_wr_en) begin
         stage_count_ff <= csr_wr_data;
      end
   end

   // Zero counts as one stage; counts above the ring size are clamped.
   always_comb begin
      if (stage_count_ff == '0) begin
         stages_used = CNT_W'(1);
      end else if (32'(stage_count_ff) > 32'(MAX_STAGES)) begin
         stages_used = CNT_W'(MAX_STAGES);
      end else begin
         stages_used = CNT_W'(stage_count_ff);
      end
   end

   // Handshake: a new request enters in idle or as the update cycle completes.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign upd_done   = !last_ff || rsp_free;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && upd_done));
   assign req_accept = req_valid && !req_stall;

   assign head    = finish[0];
   assign sum_sat = sat_add(min_ff, dur_ff);

   // Sequencer: rotate the ring once, tracking the earliest in-use stage and the latest stage.
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      pick_in         = pick_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      dur_in          = dur_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_makespan_in = rsp_makespan_ff;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN: begin
            if (idx_ff == '0) begin
               min_in  = head;
               max_in  = head;
               pick_in = '0;
            end else begin
               if ((CNT_W'(idx_ff) < stages_used) && (head < min_ff)) begin
                  min_in  = head;
                  pick_in = idx_ff;
               end
               if (head > max_ff) begin
                  max_in = head;
               end
            end
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = ST_UPDATE;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_UPDATE: begin
            if (upd_done) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_makespan_in = (sum_sat > max_ff) ? sum_sat : max_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase

      // Capture a new request; it starts the scan on the next cycle.
      if (req_accept) begin
         state_in = ST_SCAN;
         idx_in   = '0;
         dur_in   = req_duration;
         last_in  = req_last_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff         <= pick_in;
      min_ff          <= min_in;
      max_ff          <= max_in;
      dur_ff          <= dur_in;
      last_ff         <= last_in;
      rsp_makespan_ff <= rsp_makespan_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_makespan = rsp_makespan_ff;

   // Ring controls: rotate while scanning, clear after a last request, else write the pick.
   assign cell_ctrl.shift = (state_ff == ST_SCAN);
   assign cell_ctrl.clear = (state_ff == ST_UPDATE) && last_ff && upd_done;
   assign cell_ctrl.wdata = sum_sat;

   // Ring of stage cells; cell 0 sees stage k after k rotation steps.
   for (genvar gi = 0; gi < MAX_STAGES; gi++) begin : g_cell
      assign cell_load[gi] = (state_ff == ST_UPDATE) && !last_ff && (pick_ff == IDX_W'(gi));
      assign cell_busy[gi] = (finish[gi] != '0);

      lsm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .load     (cell_load[gi]),
         .shift_in (finish[(gi + 1) % MAX_STAGES]),
         .finish   (finish[gi])
      );
   end

   // Assertions.
   `LSM_ASSERT(a_rsp_from_update, clock, reset,
      $rose(rsp_valid_ff) |-> $past((state_ff == ST_UPDATE) && last_ff),
      "makespan appeared without a completed last request")
   `LSM_ASSERT_ALWAYS(a_idx_only_in_scan, clock,
      (state_ff != ST_SCAN) |-> (idx_ff == '0),
      "scan counter left nonzero outside the scan")
   `LSM_ASSERT(a_ring_cleared, clock, reset,
      ((state_ff == ST_UPDATE) && last_ff && upd_done) |=> (cell_busy == '0),
      "stage finish times not cleared after a last request")

endmodule

// File: sv/lsm_cell.sv
// One ring cell holding the finish time of a single stage.
module lsm_cell
   import lsm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lsm_cell_ctrl_type   ctrl,
   input  logic                load,
   input  logic [FINISH_W-1:0] shift_in,
   output logic [FINISH_W-1:0] finish
);

   logic [FINISH_W-1:0] finish_ff;
   logic [FINISH_W-1:0] finish_in;

   // Clear wins over a load, and a load over a rotation step.
   always_comb begin
      finish_in = finish_ff;
      if (ctrl.clear) begin
         finish_in = '0;
      end else if (load) begin
         finish_in = ctrl.wdata;
      end else if (ctrl.shift) begin
         finish_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finish_ff <= '0;
      end else begin
         finish_ff <= finish_in;
      end
   end

   assign finish = finish_ff;

endmodule
